// File: hw/rtl/rank_then_binary_radix_sort_defines.svh
// Assertion macros for the sorter checker.
`ifndef RANK_THEN_BINARY_RADIX_SORT_DEFINES_SVH
`define RANK_THEN_BINARY_RADIX_SORT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTBRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sorter assertion failed");

// Next-cycle implication, disabled during reset.
`define RTBRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sorter assertion failed");

`endif

// File: hw/rtl/rtbrs_pkg.sv
`timescale 1ns / 1ps
package rtbrs_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int VALUE_BITS = 32;
  localparam int RANK_W     = 6;
  localparam int PASS_W     = 3;
  localparam int MOVE_W     = 10;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RANK_W-1:0]            rank;
    logic                         last;
    logic [MOVE_W-1:0]            moves;
    logic                         ovf;
  } res_t;

  // Number of significant bits of a rank.
  function automatic logic [PASS_W-1:0] bit_len(input logic [RANK_W-1:0] r);
    logic [PASS_W-1:0] len;
    len = '0;
    for (int b = 0; b < RANK_W; b++) begin
      if (r[b]) len = PASS_W'(b + 1);
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/rtbrs_out_stage.sv
`timescale 1ns / 1ps
module rtbrs_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rtbrs_pkg::res_t  res_i,
  output logic             ready_o,
  input  logic             stall_i,
  output logic             valid_o,
  output rtbrs_pkg::res_t  res_o
);
  import rtbrs_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: hw/rtl/rank_then_binary_radix_sort.sv
`timescale 1ns / 1ps
// Load: one item per cycle into the value memory while idle; the last item starts the run.
// Ranking: one value-memory read per cycle for each pair of items.
// Move count: one pass per significant bit of the largest rank. Output: each result reads
// the order memory, then the value memory, and is then pushed to the output stage.
// Reset clears control state and counters; the memories keep their contents.
module rank_then_binary_radix_sort (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [rtbrs_pkg::VALUE_BITS-1:0] item_value_i,
  input  logic                                    is_last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [rtbrs_pkg::VALUE_BITS-1:0] sorted_value_o,
  output logic [rtbrs_pkg::RANK_W-1:0]            value_rank_o,
  output logic                                    end_of_run_o,
  output logic [rtbrs_pkg::MOVE_W-1:0]            run_moves_o,
  output logic                                    overflow_o
);
  import rtbrs_pkg::*;

  localparam int VR_W = VALUE_BITS + RANK_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RLD   = 9'b000000010,
    S_RLAT  = 9'b000000100,
    S_SWEEP = 9'b000001000,
    S_RWR   = 9'b000010000,
    S_PASS  = 9'b000100000,
    S_EORD  = 9'b001000000,
    S_EVAL  = 9'b010000000,
    S_EOUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [VR_W-1:0]  vr_mem  [MAX_ITEMS];
  logic [IDX_W-1:0] ord_mem [MAX_ITEMS];
  logic [VR_W-1:0]  vr_rd_q;
  logic [IDX_W-1:0] ord_rd_q;
  logic [IDX_W-1:0] vr_raddr, ord_raddr;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              ovf_q, ovf_d;
  logic [MOVE_W-1:0] move_q, move_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [IDX_W-1:0]  pj_q, pj_d;
  logic signed [VALUE_BITS-1:0] vi_q, vi_d;
  logic [RANK_W-1:0] lt_q, lt_d;
  logic [RANK_W-1:0] eq_q, eq_d;
  logic [RANK_W-1:0] maxr_q, maxr_d;
  logic [CNT_W-1:0]  ones_q [RANK_W];
  logic [CNT_W-1:0]  ones_d [RANK_W];
  logic [PASS_W-1:0] pass_q, pass_d;
  logic [PASS_W-1:0] nbits_q, nbits_d;
  logic [CNT_W-1:0]  k_q, k_d;

  logic              in_acc;
  logic              load_we;
  logic              rank_we;
  logic [IDX_W-1:0]  pos;
  logic [CNT_W-1:0]  ones_sel;
  logic signed [VALUE_BITS-1:0] vj;
  logic              out_ready, out_push;
  res_t              res_in, res_out;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_we    = in_acc && (count_q < CNT_W'(MAX_ITEMS));
  assign rank_we    = (state_q == S_RWR);
  assign pos        = IDX_W'(lt_q + eq_q);
  assign vj         = vr_rd_q[VALUE_BITS-1:0];
  assign ones_sel   = (pass_q < PASS_W'(RANK_W)) ? ones_q[pass_q] : '0;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      vr_mem[count_q[IDX_W-1:0]][VALUE_BITS-1:0] <= item_value_i;
    end else if (rank_we) begin
      vr_mem[i_q[IDX_W-1:0]][VR_W-1:VALUE_BITS] <= lt_q;
    end
    vr_rd_q <= vr_mem[vr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      ord_mem[pos] <= i_q[IDX_W-1:0];
    end
    ord_rd_q <= ord_mem[ord_raddr];
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    ovf_d     = ovf_q;
    move_d    = move_q;
    i_d       = i_q;
    j_d       = j_q;
    pj_d      = pj_q;
    vi_d      = vi_q;
    lt_d      = lt_q;
    eq_d      = eq_q;
    maxr_d    = maxr_q;
    ones_d    = ones_q;
    pass_d    = pass_q;
    nbits_d   = nbits_q;
    k_d       = k_q;
    vr_raddr  = ord_rd_q;
    ord_raddr = k_q[IDX_W-1:0];
    out_push  = 1'b0;
    res_in    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (load_we) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            n_d    = load_we ? count_q + CNT_W'(1) : count_q;
            i_d    = '0;
            maxr_d = '0;
            for (int b = 0; b < RANK_W; b++) begin
              ones_d[b] = '0;
            end
            state_d = S_RLD;
          end
        end
      end
      S_RLD: begin
        vr_raddr = i_q[IDX_W-1:0];
        state_d  = S_RLAT;
      end
      S_RLAT: begin
        vi_d     = vr_rd_q[VALUE_BITS-1:0];
        vr_raddr = '0;
        pj_d     = '0;
        j_d      = CNT_W'(1);
        lt_d     = '0;
        eq_d     = '0;
        state_d  = S_SWEEP;
      end
      S_SWEEP: begin
        vr_raddr = j_q[IDX_W-1:0];
        if (vj < vi_q) begin
          lt_d = lt_q + RANK_W'(1);
        end
        if ((vj == vi_q) && (pj_q < i_q[IDX_W-1:0])) begin
          eq_d = eq_q + RANK_W'(1);
        end
        if (j_q == n_q) begin
          state_d = S_RWR;
        end else begin
          pj_d = j_q[IDX_W-1:0];
          j_d  = j_q + CNT_W'(1);
        end
      end
      S_RWR: begin
        for (int b = 0; b < RANK_W; b++) begin
          ones_d[b] = ones_q[b] + CNT_W'(lt_q[b]);
        end
        maxr_d = (lt_q > maxr_q) ? lt_q : maxr_q;
        i_d    = i_q + CNT_W'(1);
        if (i_q + CNT_W'(1) == n_q) begin
          nbits_d = bit_len(maxr_d);
          pass_d  = '0;
          move_d  = '0;
          state_d = S_PASS;
        end else begin
          state_d = S_RLD;
        end
      end
      S_PASS: begin
        if (pass_q < nbits_q) begin
          move_d = move_q + MOVE_W'(n_q) + MOVE_W'(n_q - ones_sel);
          pass_d = pass_q + PASS_W'(1);
        end else begin
          k_d     = '0;
          state_d = S_EORD;
        end
      end
      S_EORD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_EOUT;
      end
      S_EOUT: begin
        res_in.value = vj;
        res_in.rank  = vr_rd_q[VR_W-1:VALUE_BITS];
        res_in.last  = (k_q + CNT_W'(1) == n_q);
        res_in.moves = res_in.last ? move_q : '0;
        res_in.ovf   = ovf_q;
        if (out_ready) begin
          out_push = 1'b1;
          if (res_in.last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            move_d  = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_EORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      move_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      pj_q    <= '0;
      lt_q    <= '0;
      eq_q    <= '0;
      maxr_q  <= '0;
      pass_q  <= '0;
      nbits_q <= '0;
      k_q     <= '0;
      for (int b = 0; b < RANK_W; b++) begin
        ones_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
      move_q  <= move_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pj_q    <= pj_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
      maxr_q  <= maxr_d;
      pass_q  <= pass_d;
      nbits_q <= nbits_d;
      k_q     <= k_d;
      ones_q  <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vi_q <= vi_d;
  end

  rtbrs_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .res_i   (res_in),
    .ready_o (out_ready),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (res_out)
  );

  assign sorted_value_o = res_out.value;
  assign value_rank_o   = res_out.rank;
  assign end_of_run_o   = res_out.last;
  assign run_moves_o    = res_out.moves;
  assign overflow_o     = res_out.ovf;

endmodule

// File: hw/rtl/rtbrs_checker.sv
`timescale 1ns / 1ps
`include "rank_then_binary_radix_sort_defines.svh"
module rtbrs_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic signed [rtbrs_pkg::VALUE_BITS-1:0] item_value_i,
  input logic                                    is_last_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic signed [rtbrs_pkg::VALUE_BITS-1:0] sorted_value_o,
  input logic [rtbrs_pkg::RANK_W-1:0]            value_rank_o,
  input logic                                    end_of_run_o,
  input logic [rtbrs_pkg::MOVE_W-1:0]            run_moves_o,
  input logic                                    overflow_o
);
  import rtbrs_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // A stalled result keeps its payload.
  `RTBRS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sorted_value_o) && $stable(value_rank_o) && $stable(end_of_run_o))

  // Move count only on the final result of a run.
  `RTBRS_ASSERT_IMP(a_move_end, clk_i, rst_ni, out_valid_o && !end_of_run_o, run_moves_o == '0)

  // A last item closes the input until the last result of the run enters the output stage.
  `RTBRS_ASSERT_NXT(a_last_stall, clk_i, rst_ni, in_xfer && is_last_i, in_stall_o)

  // Mid-run results only appear while input is closed.
  `RTBRS_ASSERT_IMP(a_mid_stall, clk_i, rst_ni, out_valid_o && !end_of_run_o, in_stall_o)

endmodule

bind rank_then_binary_radix_sort rtbrs_checker u_rtbrs_checker (.*);
